>>> sv/dual_sensor_temp_sequencer_assert.svh
// assertion macros used by the sequencer top module
// depends on nothing; included inside module bodies
`ifndef DUAL_SENSOR_TEMP_SEQUENCER_ASSERT_SVH
`define DUAL_SENSOR_TEMP_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sequencer assertion failed");

// next-cycle implication, disabled during reset
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequencer assertion failed");

`endif

>>> sv/dss_pkg.sv
// types and constants for the dual sensor temperature sequencer
// no dependencies
package dss_pkg;

  localparam int unsigned PhaseW   = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned TempW    = 11;

  typedef enum logic [2:0] {
    HLTH_NONE   = 3'd0,
    HLTH_BOTH   = 3'd1,
    HLTH_B_DEAD = 3'd2,
    HLTH_A_DEAD = 3'd3,
    HLTH_CPU    = 3'd4
  } health_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CPU_OFFSET    = 2'd0,
    CFG_SLEEP_TICKS   = 2'd1,
    CFG_WAKE_TICKS    = 2'd2,
    CFG_MEASURE_TICKS = 2'd3
  } cfg_idx_e;

  // sensor status codes, anything else is an error
  localparam logic [1:0] ST_STANDBY = 2'd0;
  localparam logic [1:0] ST_READY   = 2'd1;

  localparam logic signed [7:0]       CPU_OFFSET_RST = 8'sd0;
  localparam logic [4:0]              SLEEP_RST      = 5'd15;
  localparam logic [3:0]              WAKE_RST       = 4'd3;
  localparam logic [3:0]              MEASURE_RST    = 4'd2;
  localparam logic signed [TempW-1:0] TEMP_RST       = 11'sd10;

  typedef struct packed {
    logic signed [7:0] cpu_offset;
    logic [4:0]        sleep_ticks;
    logic [3:0]        wake_ticks;
    logic [3:0]        measure_ticks;
  } cfg_t;

  typedef struct packed {
    logic              rail_on;
    logic [1:0]        status_a;
    logic [1:0]        status_b;
    logic signed [7:0] reading_a;
    logic signed [7:0] reading_b;
    logic signed [9:0] cpu_temp;
  } tick_t;

  typedef struct packed {
    logic rail_on_req;
    logic rail_off_req;
    logic wake_a_req;
    logic wake_b_req;
    logic sleep_req;
  } req_t;

endpackage

>>> sv/dss_cfg.sv
// configuration register file of the sequencer
// depends on dss_pkg
module dss_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dss_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dss_pkg::CfgDataW-1:0]  cfg_data_i,
  output dss_pkg::cfg_t                 cfg_o
);
  import dss_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CPU_OFFSET:    cfg_d.cpu_offset    = cfg_data_i;
        CFG_SLEEP_TICKS:   cfg_d.sleep_ticks   = cfg_data_i[4:0];
        CFG_WAKE_TICKS:    cfg_d.wake_ticks    = cfg_data_i[3:0];
        CFG_MEASURE_TICKS: cfg_d.measure_ticks = cfg_data_i[3:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cpu_offset    <= CPU_OFFSET_RST;
      cfg_q.sleep_ticks   <= SLEEP_RST;
      cfg_q.wake_ticks    <= WAKE_RST;
      cfg_q.measure_ticks <= MEASURE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/dss_fuse.sv
// next-state logic for one tick: phase decode, sensor fusion, requests
// depends on dss_pkg; purely combinational
module dss_fuse (
  input  dss_pkg::cfg_t                     cfg_i,
  input  dss_pkg::tick_t                    tick_i,
  input  logic [dss_pkg::PhaseW-1:0]        phase_i,
  input  logic signed [dss_pkg::TempW-1:0]  held_i,
  input  dss_pkg::health_e                  health_i,
  output logic [dss_pkg::PhaseW-1:0]        phase_o,
  output logic signed [dss_pkg::TempW-1:0]  held_o,
  output dss_pkg::health_e                  health_o,
  output dss_pkg::req_t                     req_o
);
  import dss_pkg::*;

  logic [PhaseW-1:0]       cnt;
  logic [PhaseW:0]         cnt_inc;
  logic [PhaseW:0]         wake_end;
  logic [PhaseW:0]         cycle_end;
  logic signed [8:0]       sum;
  logic signed [8:0]       half;
  logic signed [TempW-1:0] cpu_fb;
  logic                    ok_a;
  logic                    ok_b;

  // rail off restarts the count before the phase decode
  assign cnt       = tick_i.rail_on ? phase_i : '0;
  assign cnt_inc   = {1'b0, cnt} + 7'd1;
  assign wake_end  = {2'b00, cfg_i.sleep_ticks} + {3'b000, cfg_i.wake_ticks};
  assign cycle_end = wake_end + {3'b000, cfg_i.measure_ticks};

  assign ok_a   = (tick_i.status_a == ST_READY);
  assign ok_b   = (tick_i.status_b == ST_READY);
  assign sum    = {tick_i.reading_a[7], tick_i.reading_a}
                + {tick_i.reading_b[7], tick_i.reading_b};
  assign half   = sum >>> 1;  // floor halving
  assign cpu_fb = {tick_i.cpu_temp[9], tick_i.cpu_temp}
                - {{3{cfg_i.cpu_offset[7]}}, cfg_i.cpu_offset};

  always_comb begin
    phase_o             = cnt_inc[PhaseW-1:0];
    held_o              = held_i;
    health_o            = health_i;
    req_o               = '0;
    req_o.rail_on_req   = !tick_i.rail_on;
    if ({1'b0, cnt} < {2'b00, cfg_i.sleep_ticks}) begin
      phase_o = cnt_inc[PhaseW-1:0];
    end else if ({1'b0, cnt} < wake_end) begin
      req_o.wake_a_req = (tick_i.status_a == ST_STANDBY);
      req_o.wake_b_req = (tick_i.status_b == ST_STANDBY);
    end else if ({1'b0, cnt} < cycle_end) begin
      if (ok_a && ok_b) begin
        held_o   = {{2{half[8]}}, half};
        health_o = HLTH_BOTH;
      end else if (ok_a) begin
        held_o   = {{3{tick_i.reading_a[7]}}, tick_i.reading_a};
        health_o = HLTH_B_DEAD;
      end else if (ok_b) begin
        held_o   = {{3{tick_i.reading_b[7]}}, tick_i.reading_b};
        health_o = HLTH_A_DEAD;
      end else begin
        held_o             = cpu_fb;
        health_o           = HLTH_CPU;
        req_o.rail_off_req = 1'b1;
      end
      if (cnt_inc >= cycle_end) begin
        phase_o         = '0;
        req_o.sleep_req = 1'b1;
      end
    end else begin
      // count beyond the cycle, e.g. after phase lengths were lowered
      phase_o = '0;
    end
  end

endmodule

>>> sv/dual_sensor_temp_sequencer.sv
// Dual sensor temperature sequencer, one result item per tick item.
// Input channel: in_valid_i/in_ready_o with the tick fields as separate ports.
// Output channel: out_valid_o/out_ready_i with pack temperature, health code
// and the rail, wake and sleep requests.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once
// (0 cpu offset, 1 sleep ticks, 2 wake ticks, 3 measure ticks); write only
// while no item is in flight.
// Result path: an accepted item loads the input register, and its result loads
// the result register once that register can advance (out_ready_i high or the
// result register empty); the phase counter, held temperature and health code
// update in the same cycle the result register loads.
// Throughput: one item per cycle while out_ready_i is high; the state feedback
// is a single compare, add and select stage, so consecutive items never wait.
// Reset: phase count 0, held temperature 10, health not set, configuration
// back to its defaults; both pipeline registers empty.
// Stall: while out_ready_i is low the result is held, one more item may sit
// in the input register, and in_ready_o drops once both are full.
// Depends on dss_pkg, dss_cfg, dss_fuse and the assertion macro header.
module dual_sensor_temp_sequencer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dss_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [dss_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 rail_on_i,
  input  logic [1:0]                           status_a_i,
  input  logic [1:0]                           status_b_i,
  input  logic signed [7:0]                    reading_a_i,
  input  logic signed [7:0]                    reading_b_i,
  input  logic signed [9:0]                    cpu_temp_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [dss_pkg::TempW-1:0]     pack_temp_o,
  output logic [2:0]                           health_o,
  output logic                                 rail_on_req_o,
  output logic                                 rail_off_req_o,
  output logic                                 wake_a_req_o,
  output logic                                 wake_b_req_o,
  output logic                                 sleep_req_o
);
  import dss_pkg::*;

  `include "dual_sensor_temp_sequencer_assert.svh"

  cfg_t                    cfg;
  tick_t                   tick_q;
  logic                    in_vq;
  logic                    out_vq;
  logic                    adv;
  logic                    step;
  logic [PhaseW-1:0]       phase_q, phase_d;
  logic signed [TempW-1:0] held_q, held_d;
  health_e                 health_q, health_d;
  req_t                    req_d, req_q;

  dss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dss_fuse u_fuse (
    .cfg_i    (cfg),
    .tick_i   (tick_q),
    .phase_i  (phase_q),
    .held_i   (held_q),
    .health_i (health_q),
    .phase_o  (phase_d),
    .held_o   (held_d),
    .health_o (health_d),
    .req_o    (req_d)
  );

  assign adv        = !out_vq || out_ready_i;
  assign step       = in_vq && adv;
  assign in_ready_o = !in_vq || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_ready_o) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      tick_q <= '{rail_on:   rail_on_i,
                  status_a:  status_a_i,
                  status_b:  status_b_i,
                  reading_a: reading_a_i,
                  reading_b: reading_b_i,
                  cpu_temp:  cpu_temp_i};
    end
  end

  // sequencer state, advanced once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      held_q   <= TEMP_RST;
      health_q <= HLTH_NONE;
    end else if (step) begin
      phase_q  <= phase_d;
      held_q   <= held_d;
      health_q <= health_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= in_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      req_q <= req_d;
    end
  end

  // the result fields are the state after the tick, so they read the state
  // registers directly
  assign out_valid_o    = out_vq;
  assign pack_temp_o    = held_q;
  assign health_o       = health_q;
  assign rail_on_req_o  = req_q.rail_on_req;
  assign rail_off_req_o = req_q.rail_off_req;
  assign wake_a_req_o   = req_q.wake_a_req;
  assign wake_b_req_o   = req_q.wake_b_req;
  assign sleep_req_o    = req_q.sleep_req;

  `DSS_ASSERT_NEXT(a_sleep_wraps_count, clk_i, rst_ni,
                   step && req_d.sleep_req, phase_q == '0)
  `DSS_ASSERT_NOW(a_off_means_cpu_only, clk_i, rst_ni,
                  out_vq && req_q.rail_off_req, health_q == HLTH_CPU)
  `DSS_ASSERT_NOW(a_wake_not_measure, clk_i, rst_ni,
                  out_vq && (req_q.wake_a_req || req_q.wake_b_req),
                  !req_q.sleep_req && !req_q.rail_off_req)
  `DSS_ASSERT_NEXT(a_health_stays_set, clk_i, rst_ni,
                   health_q != HLTH_NONE, health_q != HLTH_NONE)
  `DSS_ASSERT_NEXT(a_state_holds_on_stall, clk_i, rst_ni,
                   !step, $stable(phase_q) && $stable(held_q))

endmodule
